/* hdl/ansi_escape_terminal_cursor_top_assert.svh */
// Assertion macros used by the checker of the terminal cursor block.
`ifndef ANSI_ESCAPE_TERMINAL_CURSOR_TOP_ASSERT_SVH
`define ANSI_ESCAPE_TERMINAL_CURSOR_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define AETC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define AETC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* hdl/aetc_pkg.sv */
// Package with types and constants of the terminal escape sequence parser.
package aetc_pkg;

  // Parser phases.
  localparam logic [1:0] PH_NORMAL  = 2'd0;
  localparam logic [1:0] PH_ESC     = 2'd1;
  localparam logic [1:0] PH_BRACKET = 2'd2;
  localparam logic [1:0] PH_VALUE   = 2'd3;

  // Character codes.
  localparam logic [7:0] ESC_BYTE = 8'h1B;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_UP_J  = 8'h4A;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_M  = 8'h6D;
  localparam logic [7:0] CH_LO_S  = 8'h73;
  localparam logic [7:0] CH_LO_U  = 8'h75;

  // Tab stops fall on multiples of four.
  localparam logic [8:0] TAB_STOP = 9'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_COLUMNS = 3'd0;
  localparam logic [2:0] CFG_ROWS    = 3'd1;
  localparam logic [2:0] CFG_PALETTE = 3'd2;
  localparam logic [2:0] CFG_DEF_FG  = 3'd3;
  localparam logic [2:0] CFG_DEF_BG  = 3'd4;

  // Register reset values.
  localparam logic [7:0]  RST_COLUMNS = 8'd80;
  localparam logic [7:0]  RST_ROWS    = 8'd25;
  localparam logic [63:0] RST_PALETTE = 64'hED61_CC81_FA1E_BC80;
  localparam logic [3:0]  RST_DEF_FG  = 4'd7;
  localparam logic [3:0]  RST_DEF_BG  = 4'd0;

  // Attribute code ranges.
  localparam logic [15:0] ATTR_FG_LO  = 16'd30;
  localparam logic [15:0] ATTR_FG_HI  = 16'd37;
  localparam logic [15:0] ATTR_BG_LO  = 16'd40;
  localparam logic [15:0] ATTR_BG_HI  = 16'd47;
  localparam logic [15:0] ATTR_BFG_LO = 16'd90;
  localparam logic [15:0] ATTR_BFG_HI = 16'd97;
  localparam logic [15:0] ATTR_BBG_LO = 16'd100;
  localparam logic [15:0] ATTR_BBG_HI = 16'd107;

  // Colors produced by the attribute unit.
  typedef struct packed {
    logic [3:0] fore;
    logic [3:0] back;
  } color_t;

  // Cursor move produced by the text unit.
  typedef struct packed {
    logic [8:0] col;
    logic [8:0] row;
    logic       draw;
    logic [7:0] dx;
    logic [7:0] dy;
  } cur_move_t;

endpackage

/* hdl/aetc_attr.sv */
// Attribute unit: applies one stacked value of a color command to the colors.
module aetc_attr (
  input  logic [15:0]     value,
  input  aetc_pkg::color_t color_in,
  input  logic [63:0]     palette,
  input  logic [3:0]      def_fore,
  input  logic [3:0]      def_back,
  output aetc_pkg::color_t color_out
);
  import aetc_pkg::*;

  logic [15:0] off_fg;
  logic [15:0] off_bg;
  logic [15:0] off_bfg;
  logic [15:0] off_bbg;

  // Offsets into each color range; only the low three bits are used.
  assign off_fg  = value - ATTR_FG_LO;
  assign off_bg  = value - ATTR_BG_LO;
  assign off_bfg = value - ATTR_BFG_LO;
  assign off_bbg = value - ATTR_BBG_LO;

  // Decode the code and look up the device color in the palette; code zero restores the defaults.
  always_comb begin
    color_out = color_in;
    if (value == 16'd0) begin
      color_out.fore = def_fore;
      color_out.back = def_back;
    end else if (value >= ATTR_FG_LO && value <= ATTR_FG_HI) begin
      color_out.fore = palette[{1'b0, off_fg[2:0]} * 4 +: 4];
    end else if (value >= ATTR_BG_LO && value <= ATTR_BG_HI) begin
      color_out.back = palette[{1'b0, off_bg[2:0]} * 4 +: 4];
    end else if (value >= ATTR_BFG_LO && value <= ATTR_BFG_HI) begin
      color_out.fore = palette[{1'b1, off_bfg[2:0]} * 4 +: 4];
    end else if (value >= ATTR_BBG_LO && value <= ATTR_BBG_HI) begin
      color_out.back = palette[{1'b1, off_bbg[2:0]} * 4 +: 4];
    end
  end

endmodule

/* hdl/aetc_cursor.sv */
// Text unit: moves the cursor for a control or printable byte, with wrap and clamp.
module aetc_cursor (
  input  logic [7:0]          char_in,
  input  logic [8:0]          col,
  input  logic [8:0]          row,
  input  logic [7:0]          columns,
  input  logic [7:0]          rows,
  output aetc_pkg::cur_move_t move
);
  import aetc_pkg::*;

  logic [8:0] cols_eff;
  logic [8:0] rows_eff;
  logic [8:0] col_m;
  logic [8:0] row_m;
  logic [8:0] col_w;
  logic [8:0] row_w;
  logic       draw_m;
  logic [7:0] dx_m;
  logic [7:0] dy_m;

  // A zero geometry register acts as one.
  assign cols_eff = (columns == 8'd0) ? 9'd1 : {1'b0, columns};
  assign rows_eff = (rows == 8'd0) ? 9'd1 : {1'b0, rows};

  // Byte-specific move.
  always_comb begin
    col_m = col;
    row_m = row;
    draw_m = 1'b0;
    dx_m = 8'd0;
    dy_m = 8'd0;
    case (char_in)
      CH_BS: begin
        if (col != 9'd0) col_m = col - 9'd1;
      end
      CH_LF: begin
        col_m = 9'd0;
        row_m = row + 9'd1;
      end
      CH_TAB: begin
        col_m = (col & ~(TAB_STOP - 9'd1)) + TAB_STOP;
      end
      CH_CR: begin
        col_m = 9'd0;
      end
      default: begin
        draw_m = 1'b1;
        dx_m = col[7:0];
        dy_m = row[7:0];
        col_m = col + 9'd1;
      end
    endcase
  end

  // Wrap at the line end, then clamp at the last row.
  always_comb begin
    col_w = col_m;
    row_w = row_m;
    if (col_m >= cols_eff) begin
      col_w = 9'd0;
      row_w = row_m + 9'd1;
    end
    move.draw = draw_m;
    move.dx = dx_m;
    move.dy = dy_m;
    move.col = col_w;
    move.row = row_w;
    if (row_w >= rows_eff) begin
      move.col = 9'd0;
      move.row = rows_eff - 9'd1;
    end
  end

endmodule

/* hdl/ansi_escape_terminal_cursor_top.sv */
// Each accepted byte gives a registered output word, except a color command.
// A color command walks its stacked values, at most STACK_DEPTH, through one shared
// attribute unit, one value a cycle, the last only once the output word is free.
// The input takes one byte a cycle; a color command holds it until its values are applied.
// The input also stalls while the output word waits.
// Reset (synchronous, active high) clears the parser and cursor and restores all defaults.
module ansi_escape_terminal_cursor_top #(
  parameter int STACK_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  char_out,
  output logic        draw_valid,
  output logic [7:0]  draw_x,
  output logic [7:0]  draw_y,
  output logic [3:0]  fore_color,
  output logic [3:0]  back_color,
  output logic [7:0]  cursor_col,
  output logic [7:0]  cursor_row,
  output logic        clear_screen,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import aetc_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ATTR = 1'b1;

  // Configuration registers.
  logic [7:0]  screen_columns;
  logic [7:0]  screen_rows;
  logic [63:0] palette_map;
  logic [3:0]  default_fore;
  logic [3:0]  default_back;

  // Parser and cursor state.
  logic             state, state_next;
  logic [1:0]       phase, phase_next;
  logic [15:0]      accum, accum_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [15:0]      stack [STACK_DEPTH];
  logic [8:0]       col_pos, col_next;
  logic [8:0]       row_pos, row_next;
  logic [7:0]       saved_col, saved_col_next;
  logic [7:0]       saved_row, saved_row_next;
  color_t           color, color_next;

  logic        accept;
  logic        out_free;
  logic        text;
  logic        clr;
  logic        err;
  logic        push_en;
  logic        start_attr;
  logic        last;
  logic        step_en;
  logic        load_out;
  logic        is_digit;
  logic [7:0]  digit;
  logic [15:0] accum_x10;
  logic        room;
  cur_move_t   move;
  color_t      attr_color;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;

  assign digit     = char_in - CH_0;
  assign is_digit  = (char_in >= CH_0) && (char_in <= CH_9);
  assign accum_x10 = {accum[12:0], 3'b000} + {accum[14:0], 1'b0} + {12'd0, digit[3:0]};
  assign room      = count < CNT_W'(STACK_DEPTH);

  // Attribute walk: one stacked value per cycle, the last held while the output word waits.
  assign last    = (CNT_W'(idx) + CNT_W'(1)) == count;
  assign step_en = (state == ST_ATTR) && (!last || out_free);

  aetc_cursor u_cursor (
    .char_in (char_in),
    .col     (col_pos),
    .row     (row_pos),
    .columns (screen_columns),
    .rows    (screen_rows),
    .move    (move)
  );

  aetc_attr u_attr (
    .value     (stack[idx]),
    .color_in  (color),
    .palette   (palette_map),
    .def_fore  (default_fore),
    .def_back  (default_back),
    .color_out (attr_color)
  );

  // Byte decoder and sequencer.
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    accum_next     = accum;
    count_next     = count;
    idx_next       = idx;
    col_next       = col_pos;
    row_next       = row_pos;
    saved_col_next = saved_col;
    saved_row_next = saved_row;
    color_next     = color;
    text           = 1'b0;
    clr            = 1'b0;
    err            = 1'b0;
    push_en        = 1'b0;
    start_attr     = 1'b0;
    if (accept) begin
      unique case (phase)
        PH_NORMAL: begin
          if (char_in == ESC_BYTE) phase_next = PH_ESC;
          else text = 1'b1;
        end
        PH_ESC: begin
          if (char_in == CH_LBRK) phase_next = PH_BRACKET;
          else text = 1'b1;
        end
        PH_BRACKET: begin
          if (is_digit) begin
            accum_next = {12'd0, digit[3:0]};
            phase_next = PH_VALUE;
          end else if (char_in == CH_LO_S) begin
            saved_col_next = col_pos[7:0];
            saved_row_next = row_pos[7:0];
            phase_next = PH_NORMAL;
            accum_next = 16'd0;
            count_next = '0;
          end else if (char_in == CH_LO_U) begin
            col_next = {1'b0, saved_col};
            row_next = {1'b0, saved_row};
            phase_next = PH_NORMAL;
            accum_next = 16'd0;
            count_next = '0;
          end else begin
            text = 1'b1;
          end
        end
        PH_VALUE: begin
          if (char_in == CH_SEMI) begin
            push_en = 1'b1;
            accum_next = 16'd0;
            phase_next = PH_BRACKET;
          end else if (char_in == CH_LO_M) begin
            push_en = 1'b1;
            start_attr = 1'b1;
            idx_next = '0;
            state_next = ST_ATTR;
          end else if (char_in == CH_UP_H || char_in == CH_LO_F) begin
            if (count >= CNT_W'(2)) begin
              err = 1'b1;
            end else begin
              if (count == CNT_W'(1)) row_next = {1'b0, stack[0][7:0]};
              col_next = {1'b0, accum[7:0]};
            end
            phase_next = PH_NORMAL;
            accum_next = 16'd0;
            count_next = '0;
          end else if (char_in == CH_UP_J) begin
            if (accum == 16'd2) clr = 1'b1;
            else err = 1'b1;
            phase_next = PH_NORMAL;
            accum_next = 16'd0;
            count_next = '0;
          end else if (is_digit) begin
            accum_next = accum_x10;
          end else begin
            text = 1'b1;
          end
        end
        default: begin
          text = 1'b1;
        end
      endcase
      if (push_en && room) count_next = count + CNT_W'(1);
      // Text or control byte: leave any sequence and move the cursor.
      if (text) begin
        phase_next = PH_NORMAL;
        accum_next = 16'd0;
        count_next = '0;
        col_next   = move.col;
        row_next   = move.row;
      end
    end else if (step_en) begin
      color_next = attr_color;
      if (last) begin
        state_next = ST_IDLE;
        phase_next = PH_NORMAL;
        accum_next = 16'd0;
        count_next = '0;
      end else begin
        idx_next = idx + IDX_W'(1);
      end
    end
  end

  assign load_out = (accept && !start_attr) || (step_en && last);

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      phase          <= PH_NORMAL;
      accum          <= 16'd0;
      count          <= '0;
      idx            <= '0;
      col_pos        <= 9'd0;
      row_pos        <= 9'd0;
      saved_col      <= 8'd0;
      saved_row      <= 8'd0;
      color.fore     <= RST_DEF_FG;
      color.back     <= RST_DEF_BG;
      out_valid      <= 1'b0;
      screen_columns <= RST_COLUMNS;
      screen_rows    <= RST_ROWS;
      palette_map    <= RST_PALETTE;
      default_fore   <= RST_DEF_FG;
      default_back   <= RST_DEF_BG;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      accum     <= accum_next;
      count     <= count_next;
      idx       <= idx_next;
      col_pos   <= col_next;
      row_pos   <= row_next;
      saved_col <= saved_col_next;
      saved_row <= saved_row_next;
      color     <= color_next;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_COLUMNS: screen_columns <= cfg_data[7:0];
          CFG_ROWS:    screen_rows    <= cfg_data[7:0];
          CFG_PALETTE: palette_map    <= cfg_data;
          CFG_DEF_FG:  default_fore   <= cfg_data[3:0];
          CFG_DEF_BG:  default_back   <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // Value stack: written at the fill count.
  always_ff @(posedge clk) begin
    if (accept && push_en && room) stack[count[IDX_W-1:0]] <= accum;
  end

  // Output word.
  always_ff @(posedge clk) begin
    if (load_out) begin
      char_out     <= accept ? char_in : CH_LO_M;
      draw_valid   <= text && move.draw;
      draw_x       <= (text && move.draw) ? move.dx : 8'd0;
      draw_y       <= (text && move.draw) ? move.dy : 8'd0;
      fore_color   <= color_next.fore;
      back_color   <= color_next.back;
      cursor_col   <= col_next[7:0];
      cursor_row   <= row_next[7:0];
      clear_screen <= clr;
      status       <= err;
    end
  end

endmodule

/* hdl/aetc_checker.sv */
// Port-level checker for the terminal cursor block, bound to the top level.
`include "ansi_escape_terminal_cursor_top_assert.svh"

module aetc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] char_out,
  input logic       draw_valid,
  input logic [7:0] draw_x,
  input logic [7:0] draw_y,
  input logic       clear_screen,
  input logic       status
);
  import aetc_pkg::*;

  // A clear request comes only from a J final and is never an error or a draw.
  `AETC_ASSERT_NOW(a_clear_word, out_valid && clear_screen, char_out == CH_UP_J && !status && !draw_valid)

  // A rejected sequence ends in a cursor or clear final and draws nothing.
  `AETC_ASSERT_NOW(a_error_word, out_valid && status, (char_out == CH_UP_H || char_out == CH_LO_F || char_out == CH_UP_J) && !draw_valid)

  // Draw coordinates read zero on words that draw nothing.
  `AETC_ASSERT_NOW(a_draw_zero, out_valid && !draw_valid, draw_x == 8'd0 && draw_y == 8'd0)

  // A stalled output word stays in place.
  `AETC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(char_out) && $stable(status))

endmodule

bind ansi_escape_terminal_cursor_top aetc_checker u_aetc_checker (.*);
